### hdl/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared codes, field widths and reset values of the clipped color-key blitter.
// ----------------------------------------------------------------------------
package ccb_pkg;

	localparam int ROW_W    = 7;
	localparam int COL_W    = 7;
	localparam int WCELLS_W = 6;
	localparam int HLINES_W = 8;
	localparam int COLOR_W  = 8;

	// command field
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// result kind field
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_COLOR     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RECOLOR_SOURCE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RECOLOR_TARGET = 3'd6;

	// reset values
	localparam int CLIP_LEFT_RST   = 0;
	localparam int CLIP_RIGHT_RST  = 320;
	localparam int CLIP_TOP_RST    = 0;
	localparam int CLIP_BOTTOM_RST = 200;
	localparam logic [COLOR_W-1:0] KEY_COLOR_RST = 8'd17;

	typedef struct packed {
		logic [COLOR_W-1:0] skip;
		logic [COLOR_W-1:0] recolor_src;
		logic [COLOR_W-1:0] recolor_dst;
	} key_cfg_t;

endpackage

### hdl/ccb_if.sv
// ----------------------------------------------------------------------------
// ccb_in_if / ccb_out_if
// Valid/ready channels for source items and for blitter results.
// ----------------------------------------------------------------------------
interface ccb_in_if import ccb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic [ROW_W-1:0]    origin_row;
	logic [COL_W-1:0]    origin_col;
	logic [WCELLS_W-1:0] width_cells;
	logic [HLINES_W-1:0] height_lines;
	logic [COLOR_W-1:0]  color;
	logic                data_end;

	modport source (
		output valid, command, origin_row, origin_col, width_cells, height_lines,
			color, data_end,
		input  ready
	);
	modport sink (
		input  valid, command, origin_row, origin_col, width_cells, height_lines,
			color, data_end,
		output ready
	);
endinterface

interface ccb_out_if import ccb_pkg::*; #(
	parameter int COORD_BITS = 11
) ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  last;

	modport source (
		output valid, kind, pixel_x, pixel_y, pixel_color, last,
		input  ready
	);
	modport sink (
		input  valid, kind, pixel_x, pixel_y, pixel_color, last,
		output ready
	);
endinterface

### hdl/ccb_regs.sv
// ----------------------------------------------------------------------------
// ccb_regs
// Configuration register file: clip rectangle and color-key values.
// ----------------------------------------------------------------------------
module ccb_regs import ccb_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_wdata,
	output logic [COORD_BITS-1:0] clip_left,
	output logic [COORD_BITS-1:0] clip_right,
	output logic [COORD_BITS-1:0] clip_top,
	output logic [COORD_BITS-1:0] clip_bottom,
	output key_cfg_t              key_cfg
);

	logic [COORD_BITS-1:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
	key_cfg_t              key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q       <= COORD_BITS'(CLIP_LEFT_RST);
			clip_right_q      <= COORD_BITS'(CLIP_RIGHT_RST);
			clip_top_q        <= COORD_BITS'(CLIP_TOP_RST);
			clip_bottom_q     <= COORD_BITS'(CLIP_BOTTOM_RST);
			key_q.skip        <= KEY_COLOR_RST;
			key_q.recolor_src <= KEY_COLOR_RST;
			key_q.recolor_dst <= KEY_COLOR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:      clip_left_q       <= cfg_wdata;
				REG_CLIP_RIGHT:     clip_right_q      <= cfg_wdata;
				REG_CLIP_TOP:       clip_top_q        <= cfg_wdata;
				REG_CLIP_BOTTOM:    clip_bottom_q     <= cfg_wdata;
				REG_SKIP_COLOR:     key_q.skip        <= cfg_wdata[COLOR_W-1:0];
				REG_RECOLOR_SOURCE: key_q.recolor_src <= cfg_wdata[COLOR_W-1:0];
				REG_RECOLOR_TARGET: key_q.recolor_dst <= cfg_wdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign clip_left   = clip_left_q;
	assign clip_right  = clip_right_q;
	assign clip_top    = clip_top_q;
	assign clip_bottom = clip_bottom_q;
	assign key_cfg     = key_q;

endmodule

### hdl/ccb_core.sv
// ----------------------------------------------------------------------------
// ccb_core
// Input register, cursor and placement state, clip and color-key logic, and
// the result register with a held-over update marker.
// ----------------------------------------------------------------------------
module ccb_core import ccb_pkg::*; #(
	parameter int COORD_BITS  = 11,
	parameter int CELL_PIXELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [COORD_BITS-1:0] clip_left,
	input  logic [COORD_BITS-1:0] clip_right,
	input  logic [COORD_BITS-1:0] clip_top,
	input  logic [COORD_BITS-1:0] clip_bottom,
	input  key_cfg_t              key_cfg,
	ccb_in_if.sink                pix_in,
	ccb_out_if.source             res_out
);

	localparam int SUM_W = COORD_BITS + 8;

	// input register
	logic                  valid_s1;
	logic                  command_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1;
	logic [WCELLS_W-1:0]   wcells_s1;
	logic [HLINES_W-1:0]   hlines_s1;
	logic [COLOR_W-1:0]    color_s1;
	logic                  data_end_s1;

	// picture state
	logic                  busy_q;
	logic [COORD_BITS-1:0] base_x_q, end_x_q, end_y_q, cursor_x_q, cursor_y_q;

	// result register and pending marker
	logic                  out_valid_q;
	logic                  kind_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic [COLOR_W-1:0]    pcolor_q;
	logic                  last_q;
	logic                  mark_q;

	logic                  take, slot_free, go;

	// combinational results of the item in the input register
	logic [SUM_W-1:0]      base_full, top_full, endx_full, endy_full;
	logic [COORD_BITS-1:0] st_base, st_top, st_endx, st_endy;
	logic                  st_empty;
	logic [COORD_BITS-1:0] nx_step, ny_step, nx, ny;
	logic                  wrap_x, done, in_clip, wr;
	logic [COLOR_W-1:0]    wcolor;
	logic                  first_v, first_kind, first_last, second_v;

	assign take      = out_valid_q && res_out.ready;
	assign slot_free = (!out_valid_q || res_out.ready) && !mark_q;
	assign go        = valid_s1 && slot_free;
	assign pix_in.ready = !valid_s1 || go;

	always_comb begin
		base_full = SUM_W'(col_s1) * SUM_W'(CELL_PIXELS);
		top_full  = SUM_W'(row_s1) * SUM_W'(CELL_PIXELS);
		st_base   = base_full[COORD_BITS-1:0];
		st_top    = top_full[COORD_BITS-1:0];
		endx_full = SUM_W'(st_base) + SUM_W'(wcells_s1) * SUM_W'(CELL_PIXELS);
		endy_full = SUM_W'(st_top) + SUM_W'(hlines_s1);
		st_endx   = endx_full[COORD_BITS-1:0];
		st_endy   = endy_full[COORD_BITS-1:0];
		st_empty  = (wcells_s1 == '0) || (hlines_s1 == '0);

		nx_step = cursor_x_q + COORD_BITS'(1);
		ny_step = cursor_y_q + COORD_BITS'(1);
		wrap_x  = (nx_step == end_x_q);
		nx      = wrap_x ? base_x_q : nx_step;
		ny      = wrap_x ? ny_step : cursor_y_q;
		done    = data_end_s1 || (wrap_x && (ny_step == end_y_q));
		in_clip = (cursor_x_q >= clip_left) && (cursor_x_q < clip_right) &&
			(cursor_y_q >= clip_top) && (cursor_y_q < clip_bottom);
		wr      = in_clip && (color_s1 != key_cfg.skip);
		wcolor  = (color_s1 == key_cfg.recolor_src) ? key_cfg.recolor_dst : color_s1;

		first_v    = 1'b0;
		first_kind = KIND_UPDATE;
		first_last = 1'b1;
		second_v   = 1'b0;
		if (command_s1 == CMD_START) begin
			first_v = st_empty;
		end else if (busy_q) begin
			if (wr) begin
				first_v    = 1'b1;
				first_kind = KIND_WRITE;
				first_last = !done;
				second_v   = done;
			end else begin
				first_v = done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && pix_in.ready) begin
			command_s1  <= pix_in.command;
			row_s1      <= pix_in.origin_row;
			col_s1      <= pix_in.origin_col;
			wcells_s1   <= pix_in.width_cells;
			hlines_s1   <= pix_in.height_lines;
			color_s1    <= pix_in.color;
			data_end_s1 <= pix_in.data_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			base_x_q   <= '0;
			end_x_q    <= '0;
			end_y_q    <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (go) begin
			if (command_s1 == CMD_START) begin
				busy_q     <= !st_empty;
				base_x_q   <= st_base;
				end_x_q    <= st_endx;
				end_y_q    <= st_endy;
				cursor_x_q <= st_base;
				cursor_y_q <= st_top;
			end else if (busy_q) begin
				busy_q     <= !done;
				cursor_x_q <= nx;
				cursor_y_q <= ny;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mark_q      <= 1'b0;
		end else if (take && mark_q) begin
			out_valid_q <= 1'b1;
			mark_q      <= 1'b0;
		end else if (go && first_v) begin
			out_valid_q <= 1'b1;
			mark_q      <= second_v;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && mark_q) begin
			kind_q   <= KIND_UPDATE;
			px_q     <= '0;
			py_q     <= '0;
			pcolor_q <= '0;
			last_q   <= 1'b1;
		end else if (go && first_v) begin
			kind_q   <= first_kind;
			px_q     <= (first_kind == KIND_WRITE) ? cursor_x_q : '0;
			py_q     <= (first_kind == KIND_WRITE) ? cursor_y_q : '0;
			pcolor_q <= (first_kind == KIND_WRITE) ? wcolor : '0;
			last_q   <= first_last;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.kind        = kind_q;
	assign res_out.pixel_x     = px_q;
	assign res_out.pixel_y     = py_q;
	assign res_out.pixel_color = pcolor_q;
	assign res_out.last        = last_q;

endmodule

### hdl/clipped_color_key_blitter_top.sv
// ----------------------------------------------------------------------------
// clipped_color_key_blitter_top
// Picture blitter with clip rectangle, transparent color and one recolor.
// ----------------------------------------------------------------------------
// A start beat places a picture (origin in cells of CELL_PIXELS, width in
// cells, height in lines); each following pixel beat steps the cursor in
// raster order and yields a pixel write when it lies in the clip rectangle
// and is not the skip color. After the last pixel, or a pixel flagged
// data_end, one update marker follows with last set. Each source beat is
// taken into an input register and its results go on to the output register
// when that register is free, so one source beat is taken per cycle while
// results are drained. A beat that yields both a write and the marker holds
// the single output register for two beats, so the next source beat waits
// until the write has been taken. Configuration is written through the plain
// write port and must not change while a picture is being processed.
// ----------------------------------------------------------------------------
module clipped_color_key_blitter_top import ccb_pkg::*; #(
	parameter int COORD_BITS  = 11,
	parameter int CELL_PIXELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_wdata,
	ccb_in_if.sink                pix_in,
	ccb_out_if.source             res_out
);

	logic [COORD_BITS-1:0] clip_left, clip_right, clip_top, clip_bottom;
	key_cfg_t              key_cfg;

	ccb_regs #(
		.COORD_BITS (COORD_BITS)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.clip_left   (clip_left),
		.clip_right  (clip_right),
		.clip_top    (clip_top),
		.clip_bottom (clip_bottom),
		.key_cfg     (key_cfg)
	);

	ccb_core #(
		.COORD_BITS  (COORD_BITS),
		.CELL_PIXELS (CELL_PIXELS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.clip_left   (clip_left),
		.clip_right  (clip_right),
		.clip_top    (clip_top),
		.clip_bottom (clip_bottom),
		.key_cfg     (key_cfg),
		.pix_in      (pix_in),
		.res_out     (res_out)
	);

endmodule

### verif/tb_clipped_color_key_blitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_color_key_blitter_top
// Self-checking bench for the clipped color-key blitter: a queued source
// driver, a result monitor against a cycle-free picture predictor, several
// clip and key settings, directed corner pictures and random pictures.
// ----------------------------------------------------------------------------
module tb_clipped_color_key_blitter_top;
	import ccb_pkg::*;

	localparam int COORD_W = 11;
	localparam int CELL_PX = 8;

	typedef struct {
		logic                command;
		logic [ROW_W-1:0]    origin_row;
		logic [COL_W-1:0]    origin_col;
		logic [WCELLS_W-1:0] width_cells;
		logic [HLINES_W-1:0] height_lines;
		logic [COLOR_W-1:0]  color;
		logic                data_end;
	} src_beat_t;

	typedef struct {
		logic               kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} blit_res_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_wdata = '0;

	ccb_in_if                            src_if ();
	ccb_out_if #(.COORD_BITS(COORD_W))   res_if ();

	clipped_color_key_blitter_top #(
		.COORD_BITS (COORD_W),
		.CELL_PIXELS(CELL_PX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_in   (src_if),
		.res_out  (res_if)
	);

	// driven source beat and sink ready
	src_beat_t offer      = '{default: '0};
	logic      src_valid  = 1'b0;
	logic      sink_ready = 1'b0;

	assign src_if.valid        = src_valid;
	assign src_if.command      = offer.command;
	assign src_if.origin_row   = offer.origin_row;
	assign src_if.origin_col   = offer.origin_col;
	assign src_if.width_cells  = offer.width_cells;
	assign src_if.height_lines = offer.height_lines;
	assign src_if.color        = offer.color;
	assign src_if.data_end     = offer.data_end;
	assign res_if.ready        = sink_ready;

	// predictor copy of the registers
	logic [COORD_W-1:0] clip_l   = COORD_W'(CLIP_LEFT_RST);
	logic [COORD_W-1:0] clip_r   = COORD_W'(CLIP_RIGHT_RST);
	logic [COORD_W-1:0] clip_t   = COORD_W'(CLIP_TOP_RST);
	logic [COORD_W-1:0] clip_b   = COORD_W'(CLIP_BOTTOM_RST);
	logic [COLOR_W-1:0] key_skip = KEY_COLOR_RST;
	logic [COLOR_W-1:0] key_from = KEY_COLOR_RST;
	logic [COLOR_W-1:0] key_to   = KEY_COLOR_RST;

	// predictor copy of the picture state
	logic               pic_busy = 1'b0;
	logic [COORD_W-1:0] base_x   = '0;
	logic [COORD_W-1:0] end_x    = '0;
	logic [COORD_W-1:0] end_y    = '0;
	logic [COORD_W-1:0] cur_x    = '0;
	logic [COORD_W-1:0] cur_y    = '0;

	src_beat_t src_backlog[$];
	blit_res_t blit_due[$];
	int        err_count = 0;
	int        beats_out = 0;
	int        cyc       = 0;
	logic      calm;
	logic      open_pic  = 1'b0;

	// no idling on either side over this window
	assign calm = (cyc >= 3000) && (cyc < 4500);

	always #4 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic blit_res_t update_marker();
		blit_res_t r;
		r = '{kind: KIND_UPDATE, x: '0, y: '0, color: '0, last: 1'b1};
		return r;
	endfunction

	task automatic blit_step(input src_beat_t b);
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic               done;
		logic               in_clip;
		blit_res_t          r;
		if (b.command == CMD_START) begin
			top    = COORD_W'(b.origin_row * CELL_PX);
			base_x = COORD_W'(b.origin_col * CELL_PX);
			end_x  = base_x + COORD_W'(b.width_cells * CELL_PX);
			end_y  = top + COORD_W'(b.height_lines);
			cur_x  = base_x;
			cur_y  = top;
			if (b.width_cells == 0 || b.height_lines == 0) begin
				pic_busy = 1'b0;
				blit_due.push_back(update_marker());
			end else begin
				pic_busy = 1'b1;
			end
		end else if (pic_busy) begin
			px      = cur_x;
			py      = cur_y;
			done    = b.data_end;
			in_clip = px >= clip_l && px < clip_r && py >= clip_t && py < clip_b;
			cur_x   = cur_x + COORD_W'(1);
			if (cur_x == end_x) begin
				cur_x = base_x;
				cur_y = cur_y + COORD_W'(1);
				if (cur_y == end_y)
					done = 1'b1;
			end
			if (in_clip && b.color != key_skip) begin
				r.kind  = KIND_WRITE;
				r.x     = px;
				r.y     = py;
				r.color = (b.color == key_from) ? key_to : b.color;
				r.last  = ~done;
				blit_due.push_back(r);
			end
			if (done) begin
				pic_busy = 1'b0;
				blit_due.push_back(update_marker());
			end
		end
	endtask

	// source driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (src_valid && src_if.ready)
				blit_step(offer);
			if (!src_valid || src_if.ready) begin
				if (src_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
					offer     <= src_backlog.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, with one long hold-off to back the block up
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		blit_res_t e;
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			if (res_if.valid && sink_ready) begin
				beats_out = beats_out + 1;
				if (blit_due.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result beat kind %0d x %0d y %0d color %0d last %0d",
						$time, res_if.kind, res_if.pixel_x, res_if.pixel_y,
						res_if.pixel_color, res_if.last);
				end else begin
					e = blit_due.pop_front();
					if (res_if.kind !== e.kind) begin
						err_count++;
						$display("%0t: kind expected %0d got %0d", $time, e.kind, res_if.kind);
					end
					if (res_if.pixel_x !== e.x) begin
						err_count++;
						$display("%0t: pixel_x expected %0d got %0d", $time, e.x, res_if.pixel_x);
					end
					if (res_if.pixel_y !== e.y) begin
						err_count++;
						$display("%0t: pixel_y expected %0d got %0d", $time, e.y, res_if.pixel_y);
					end
					if (res_if.pixel_color !== e.color) begin
						err_count++;
						$display("%0t: pixel_color expected %0d got %0d",
							$time, e.color, res_if.pixel_color);
					end
					if (res_if.last !== e.last) begin
						err_count++;
						$display("%0t: last expected %0d got %0d", $time, e.last, res_if.last);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				sink_ready <= 1'b0;
			end else if (!hold_done && beats_out >= 150) begin
				hold_done = 1'b1;
				hold_left = 400;
				sink_ready <= 1'b0;
			end else begin
				sink_ready <= calm || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	task automatic push_start(input int row, input int col, input int w, input int h);
		src_beat_t b;
		b              = '{default: '0};
		b.command      = CMD_START;
		b.origin_row   = ROW_W'(row);
		b.origin_col   = COL_W'(col);
		b.width_cells  = WCELLS_W'(w);
		b.height_lines = HLINES_W'(h);
		src_backlog.push_back(b);
	endtask

	task automatic push_pixel(input logic [COLOR_W-1:0] color, input logic fin);
		src_beat_t b;
		b          = '{default: '0};
		b.command  = CMD_PIXEL;
		b.color    = color;
		b.data_end = fin;
		src_backlog.push_back(b);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int value);
		logic [COORD_W-1:0] v;
		v = COORD_W'(value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_CLIP_LEFT:      clip_l   = v;
			REG_CLIP_RIGHT:     clip_r   = v;
			REG_CLIP_TOP:       clip_t   = v;
			REG_CLIP_BOTTOM:    clip_b   = v;
			REG_SKIP_COLOR:     key_skip = v[COLOR_W-1:0];
			REG_RECOLOR_SOURCE: key_from = v[COLOR_W-1:0];
			REG_RECOLOR_TARGET: key_to   = v[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int l, input int r, input int t, input int b,
		input int s, input int f, input int d);
		reg_write(REG_CLIP_LEFT, l);
		reg_write(REG_CLIP_RIGHT, r);
		reg_write(REG_CLIP_TOP, t);
		reg_write(REG_CLIP_BOTTOM, b);
		reg_write(REG_SKIP_COLOR, s);
		reg_write(REG_RECOLOR_SOURCE, f);
		reg_write(REG_RECOLOR_TARGET, d);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// origin cell near one of the two clip edges, sometimes anywhere
	function automatic int pick_cell(input int lo_px, input int hi_px);
		int c;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 127);
		c = ($urandom_range(0, 1) ? lo_px : hi_px) / CELL_PX - 3 + $urandom_range(0, 4);
		if (c < 0)
			c = 0;
		if (c > 127)
			c = 127;
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return key_skip;
		if (r < 40)
			return key_from;
		return COLOR_W'($urandom_range(0, 255));
	endfunction

	task automatic gen_pictures(input int quota);
		int   made;
		int   w;
		int   h;
		int   total;
		int   n;
		int   lim;
		int   mode;
		logic fin;
		made = 0;
		while (made < quota) begin
			// stray pixel with nothing open: dropped by the block
			if (!open_pic && $urandom_range(0, 9) == 0) begin
				push_pixel(COLOR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				continue;
			end
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1)) begin
					w = 0;
					h = $urandom_range(0, 255);
				end else begin
					w = $urandom_range(0, 63);
					h = 0;
				end
				push_start(pick_cell(clip_t, clip_b), pick_cell(clip_l, clip_r), w, h);
				open_pic = 1'b0;
				made++;
				continue;
			end
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(4, 63);
				h = $urandom_range(1, 255);
			end else begin
				w = $urandom_range(1, 3);
				h = $urandom_range(1, 4);
			end
			total = w * CELL_PX * h;
			lim   = (total < 40) ? total : 40;
			push_start(pick_cell(clip_t, clip_b), pick_cell(clip_l, clip_r), w, h);
			made++;
			mode = $urandom_range(0, 99);
			if (total > 200 && mode < 60)
				mode = 70;
			if (mode < 60) begin
				n   = total;
				fin = ($urandom_range(0, 2) == 0);
			end else if (mode < 80) begin
				n   = $urandom_range(1, lim);
				fin = 1'b1;
			end else begin
				n   = $urandom_range(0, lim - 1);
				fin = 1'b0;
			end
			for (int i = 0; i < n; i++)
				push_pixel(pick_color(), fin && (i == n - 1));
			made += n;
			// an abandoned picture stays open until the next start
			open_pic = (mode >= 80);
		end
		// zero width start closes the phase with the block idle
		push_start($urandom_range(0, 127), $urandom_range(0, 127), 0, $urandom_range(0, 255));
		open_pic = 1'b0;
	endtask

	task automatic drain();
		while (src_backlog.size() != 0 || src_valid || blit_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int l;
		int t;
		int s;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// corner pictures under the reset clip and keys
		push_start(0, 0, 0, 5);
		push_start(127, 127, 63, 0);
		push_start(0, 39, 1, 1);
		push_pixel(8'd17, 1'b0);
		push_pixel(8'h00, 1'b0);
		push_pixel(8'hFF, 1'b0);
		push_pixel(8'hAA, 1'b0);
		push_pixel(8'h55, 1'b0);
		push_pixel(8'h01, 1'b0);
		push_pixel(8'h80, 1'b0);
		push_pixel(8'h7F, 1'b1);
		push_start(24, 39, 2, 255);
		for (int i = 0; i < 9; i++)
			push_pixel(COLOR_W'($urandom_range(0, 255)), 1'b0);
		push_start(1, 1, 63, 255);
		push_pixel(8'd17, 1'b0);
		push_pixel(8'h3C, 1'b1);
		push_pixel(8'hC3, 1'b0);
		gen_pictures(300);
		drain();

		apply_setting(0, 2047, 0, 2047, 0, 255, 0);
		gen_pictures(300);
		drain();

		// empty clip rectangle: markers only
		apply_setting(2047, 0, 2047, 0, 255, 0, 255);
		gen_pictures(100);
		drain();

		repeat (4) begin
			l = $urandom_range(0, 400);
			t = $urandom_range(0, 400);
			s = $urandom_range(0, 255);
			apply_setting(l, l + $urandom_range(0, 300), t, t + $urandom_range(0, 300), s,
				$urandom_range(0, 3) == 0 ? s : $urandom_range(0, 255), $urandom_range(0, 255));
			gen_pictures(300);
			drain();
		end

		if (blit_due.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected results never arrived", $time, blit_due.size());
		end
		if (err_count == 0)
			$display("tb_clipped_color_key_blitter_top OK");
		else
			$display("tb_clipped_color_key_blitter_top NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_clipped_color_key_blitter_top NOT OK");
		$finish;
	end

endmodule

### clipped_color_key_blitter_top.f
hdl/ccb_pkg.sv
hdl/ccb_if.sv
hdl/ccb_regs.sv
hdl/ccb_core.sv
hdl/clipped_color_key_blitter_top.sv
verif/tb_clipped_color_key_blitter_top.sv
